// File: rtl/bb3_pkg.sv
// Shared constants, types and helpers for the 3x3 RGB box blur.
package bb3_pkg;

    // Default frame limits, handed to the top-level parameters
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Configuration register layout
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
    localparam int MIN_DIM = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } t_cfg_idx;

    // Pixel and channel widths
    localparam int CH_W  = 8;
    localparam int NUM_CH = 3;
    localparam int PX_W  = CH_W * NUM_CH;

    // Nine 8-bit values sum to at most 2295, which fits 12 bits
    localparam int SUM_W = 12;

    // Divide by nine: multiply by ceil(2^15 / 9) and drop 15 bits.
    // Exact for every sum below 4096.
    localparam int MEAN_SHIFT = 15;
    localparam logic [SUM_W-1:0] MEAN_MUL = 12'd3641;
    localparam int PROD_W = 2 * SUM_W;

    // Clamp a written dimension into the supported range
    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int max_dim);
        int r;
        r = int'(v);
        if (r < MIN_DIM) begin
            r = MIN_DIM;
        end else if (r > max_dim) begin
            r = max_dim;
        end
        return r;
    endfunction

endpackage

// File: rtl/box_blur_3x3_rgb.sv
// Top level of the streaming 3x3 RGB box blur.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | sink      | i_in_valid / o_in_ready    | i_red, i_green, i_blue, i_frame_start
//  out     | source    | o_out_valid / i_out_ready  | o_red_mean, o_green_mean,
//          |           |                            | o_blue_mean, o_frame_end
//  cfg     | sink      | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// One pixel per clock sustained while the output is not stalled. A pixel is read from the
// line store at acceptance, summed into stage two and divided on its way into the output
// register; the single line store port pair sets the one-pixel-per-cycle figure.
// Synchronous active-low reset clears counters, window and valid flags; the line store is
// not cleared. A stalled output holds its transaction while further pixels keep moving in
// behind it until stage two holds a result and stage one a pixel.
module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration
    input  logic                          i_cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]     i_cfg_data,
    // Pixel input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bb3_pkg::CH_W-1:0]      i_red,
    input  logic [bb3_pkg::CH_W-1:0]      i_green,
    input  logic [bb3_pkg::CH_W-1:0]      i_blue,
    input  logic                          i_frame_start,
    // Result output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bb3_pkg::CH_W-1:0]      o_red_mean,
    output logic [bb3_pkg::CH_W-1:0]      o_green_mean,
    output logic [bb3_pkg::CH_W-1:0]      o_blue_mean,
    output logic                          o_frame_end
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int DW = $clog2(MAX_WIDTH + 1);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PX_W = bb3_pkg::PX_W;
    localparam int CH_W = bb3_pkg::CH_W;

    // Geometry, stored already clamped
    logic [DW-1:0] r_width;
    logic [DW-1:0] r_w_last;
    logic [HW-1:0] r_height;
    logic [HW-1:0] r_h_last;

    // Position of the next pixel
    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;

    // Stage one: line store read returned
    logic            r_s1_valid;
    logic [XW-1:0]   r_s1_x;
    logic [PX_W-1:0] r_s1_px;
    logic            r_s1_y1;
    logic            r_s1_y2;
    logic            r_s1_emit;
    logic            r_s1_fend;

    // Stage two: sums held in the lanes
    logic            r_s2_valid;
    logic            r_s2_fend;

    // Output register
    logic            r_out_valid;
    logic [CH_W-1:0] r_out_mean [bb3_pkg::NUM_CH];
    logic            r_out_fend;

    logic            accept;
    logic            out_free;
    logic            s2_free;
    logic            s2_go;
    logic            s1_free;
    logic            s1_go;

    logic [XW-1:0]   x0;
    logic [XW-1:0]   cur_x;
    logic [HW-1:0]   cy;
    logic [YW-1:0]   cur_y;
    logic [DW-1:0]   nx;
    logic [XW-1:0]   n_col;
    logic [HW-1:0]   ny;
    logic [PX_W-1:0] in_px;

    logic [2*PX_W-1:0] rd_data;
    logic [PX_W-1:0]   top_px;
    logic [PX_W-1:0]   mid_px;
    logic [CH_W-1:0]   lane_mean [bb3_pkg::NUM_CH];

    // Handshake chain, output back to input
    assign out_free   = !r_out_valid || i_out_ready;
    assign s2_go      = r_s2_valid && out_free;
    assign s2_free    = !r_s2_valid || out_free;
    assign s1_go      = r_s1_valid && s2_free;
    assign s1_free    = !r_s1_valid || s2_free;
    assign o_in_ready = s1_free;
    assign accept     = i_in_valid && s1_free;

    assign in_px = {i_red, i_green, i_blue};

    // Place the pixel and work out the following position
    always_comb begin
        x0 = i_frame_start ? '0 : r_col;
        cy = i_frame_start ? '0 : HW'(r_row);
        if (DW'(x0) >= r_width) begin
            cur_x = '0;
            cy    = cy + HW'(1);
        end else begin
            cur_x = x0;
        end
        if (cy >= r_height) begin
            cy = '0;
        end
        cur_y = cy[YW-1:0];

        nx = DW'(cur_x) + DW'(1);
        if (nx >= r_width) begin
            n_col = '0;
            ny    = HW'(cur_y) + HW'(1);
            if (ny >= r_height) begin
                ny = '0;
            end
        end else begin
            n_col = nx[XW-1:0];
            ny    = HW'(cur_y);
        end
    end

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DW'(bb3_pkg::clamp_dim(bb3_pkg::WIDTH_RESET, MAX_WIDTH));
            r_w_last <= DW'(bb3_pkg::clamp_dim(bb3_pkg::WIDTH_RESET, MAX_WIDTH) - 1);
            r_height <= HW'(bb3_pkg::clamp_dim(bb3_pkg::HEIGHT_RESET, MAX_HEIGHT));
            r_h_last <= HW'(bb3_pkg::clamp_dim(bb3_pkg::HEIGHT_RESET, MAX_HEIGHT) - 1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bb3_pkg::CFG_IMAGE_WIDTH: begin
                    r_width  <= DW'(bb3_pkg::clamp_dim(i_cfg_data, MAX_WIDTH));
                    r_w_last <= DW'(bb3_pkg::clamp_dim(i_cfg_data, MAX_WIDTH) - 1);
                end
                bb3_pkg::CFG_IMAGE_HEIGHT: begin
                    r_height <= HW'(bb3_pkg::clamp_dim(i_cfg_data, MAX_HEIGHT));
                    r_h_last <= HW'(bb3_pkg::clamp_dim(i_cfg_data, MAX_HEIGHT) - 1);
                end
                default: begin
                end
            endcase
        end
    end

    // Advance position counters on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= ny[YW-1:0];
        end
    end

    // Pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= accept;
            end
            if (s2_free) begin
                r_s2_valid <= s1_go && r_s1_emit;
            end
            if (out_free) begin
                r_out_valid <= s2_go;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x    <= cur_x;
            r_s1_px   <= in_px;
            r_s1_y1   <= (cur_y != '0);
            r_s1_y2   <= (cur_y >= YW'(2));
            r_s1_emit <= (cur_x >= XW'(2)) && (cur_y >= YW'(2));
            r_s1_fend <= (DW'(cur_x) == r_w_last) && (HW'(cur_y) == r_h_last);
        end
        if (s1_go) begin
            r_s2_fend <= r_s1_fend;
        end
        if (s2_go) begin
            for (int c = 0; c < bb3_pkg::NUM_CH; c++) begin
                r_out_mean[c] <= lane_mean[c];
            end
            r_out_fend <= r_s2_fend;
        end
    end

    // Line stores: upper half holds line y-1, lower half line y-2
    bb3_ram #(
        .WIDTH (2 * PX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_s1_x),
        .i_wdata ({r_s1_px, mid_px}),
        .i_re    (accept),
        .i_raddr (cur_x),
        .o_rdata (rd_data)
    );

    // Drop line store data on the first two lines of a frame
    assign top_px = r_s1_y2 ? rd_data[PX_W-1:0]      : '0;
    assign mid_px = r_s1_y1 ? rd_data[2*PX_W-1:PX_W] : '0;

    // One lane per colour channel, red first
    for (genvar c = 0; c < bb3_pkg::NUM_CH; c++) begin : g_lane
        localparam int LSB = PX_W - CH_W * (c + 1);
        bb3_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (s1_go),
            .i_top   (top_px[LSB +: CH_W]),
            .i_mid   (mid_px[LSB +: CH_W]),
            .i_bot   (r_s1_px[LSB +: CH_W]),
            .o_mean  (lane_mean[c])
        );
    end

    assign o_out_valid  = r_out_valid;
    assign o_red_mean   = r_out_mean[0];
    assign o_green_mean = r_out_mean[1];
    assign o_blue_mean  = r_out_mean[2];
    assign o_frame_end  = r_out_fend;

endmodule

// File: rtl/bb3_ram.sv
// Generic simple dual-port RAM with a registered read port.
module bb3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bb3_lane.sv
// One colour channel: 3x3 window columns, neighbourhood sum and divide by nine.
module bb3_lane (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_shift,
    input  logic [bb3_pkg::CH_W-1:0] i_top,
    input  logic [bb3_pkg::CH_W-1:0] i_mid,
    input  logic [bb3_pkg::CH_W-1:0] i_bot,
    output logic [bb3_pkg::CH_W-1:0] o_mean
);

    // Oldest column and next column, each top, middle, bottom
    logic [bb3_pkg::CH_W-1:0]  r_col_old [3];
    logic [bb3_pkg::CH_W-1:0]  r_col_mid [3];
    logic [bb3_pkg::SUM_W-1:0] r_sum;
    logic [bb3_pkg::SUM_W-1:0] n_sum;
    logic [bb3_pkg::SUM_W-1:0] sum_old;
    logic [bb3_pkg::SUM_W-1:0] sum_mid;
    logic [bb3_pkg::SUM_W-1:0] sum_new;
    logic [bb3_pkg::PROD_W-1:0] prod;

    // Add up the three columns of the window
    always_comb begin
        sum_old = bb3_pkg::SUM_W'(r_col_old[0]) + bb3_pkg::SUM_W'(r_col_old[1])
                + bb3_pkg::SUM_W'(r_col_old[2]);
        sum_mid = bb3_pkg::SUM_W'(r_col_mid[0]) + bb3_pkg::SUM_W'(r_col_mid[1])
                + bb3_pkg::SUM_W'(r_col_mid[2]);
        sum_new = bb3_pkg::SUM_W'(i_top) + bb3_pkg::SUM_W'(i_mid) + bb3_pkg::SUM_W'(i_bot);
        n_sum   = sum_old + sum_mid + sum_new;
    end

    // Advance the window and capture the sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_col_old[k] <= '0;
                r_col_mid[k] <= '0;
            end
        end else if (i_shift) begin
            for (int k = 0; k < 3; k++) begin
                r_col_old[k] <= r_col_mid[k];
            end
            r_col_mid[0] <= i_top;
            r_col_mid[1] <= i_mid;
            r_col_mid[2] <= i_bot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sum <= n_sum;
        end
    end

    // Divide by nine through the reciprocal
    assign prod   = bb3_pkg::PROD_W'(r_sum) * bb3_pkg::PROD_W'(bb3_pkg::MEAN_MUL);
    assign o_mean = prod[bb3_pkg::MEAN_SHIFT +: bb3_pkg::CH_W];

endmodule

// File: rtl/bb3_chk.sv
// Port-level checker for the box blur, bound to the top level.
module bb3_chk (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic [bb3_pkg::CH_W-1:0] o_red_mean,
    input logic [bb3_pkg::CH_W-1:0] o_green_mean,
    input logic [bb3_pkg::CH_W-1:0] o_blue_mean,
    input logic                     o_frame_end
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_red_mean) && $stable(o_green_mean)
            && $stable(o_blue_mean) && $stable(o_frame_end))
        else $error("result payload changed while stalled");

    // Reset empties the output register
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Without a pending result the pipeline never back-pressures
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind box_blur_3x3_rgb bb3_chk u_bb3_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_red_mean   (o_red_mean),
    .o_green_mean (o_green_mean),
    .o_blue_mean  (o_blue_mean),
    .o_frame_end  (o_frame_end)
);
